### src/krt_pkg.sv
// Shared types and constants of the keyed record table.
// Used by krt_ctrl, the top, the checker and the bench; depends on nothing else.
`default_nettype none

package krt_pkg;

    // Field widths of one record and of one request.
    localparam int KEY_W    = 64;
    localparam int STATE_W  = 8;
    localparam int SIZE_W   = 64;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPSERT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_STATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

    // State reported when no record matches.
    localparam logic [STATE_W-1:0] MISS_STATE = 8'd1;

    // Configuration register indexes (one address bit selects them).
    localparam logic REG_DELETED_CODE  = 1'b0;
    localparam logic REG_MODIFIED_CODE = 1'b1;

    // One stored record, also the payload of a request.
    typedef struct packed {
        logic [KEY_W-1:0]   key_high;
        logic [KEY_W-1:0]   key_low;
        logic [STATE_W-1:0] state;
        logic [SIZE_W-1:0]  size;
    } t_rec;

    // Result handed from the controller to the output stage.
    typedef struct packed {
        logic                found;
        logic [STATE_W-1:0]  state;
        logic [SIZE_W-1:0]   size;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

### src/krt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing else.
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/krt_ctrl.sv
// Sequencer of the keyed record table: scans the record RAM, applies the
// operation and closes gaps on removal. Depends on krt_pkg and krt_ram.
`default_nettype none

module krt_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire logic [krt_pkg::MODE_W-1:0]  i_mode,
    input  wire krt_pkg::t_rec               i_rec,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output krt_pkg::t_result                 o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int OW = (CW > krt_pkg::COUNT_W) ? CW : krt_pkg::COUNT_W;
    localparam int RW = $bits(krt_pkg::t_rec);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SHIFT,
        S_FIN
    } t_state;

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_count, n_count;
    logic [krt_pkg::MODE_W-1:0]    r_mode;
    krt_pkg::t_rec                 r_req;
    logic                          r_hit, n_hit;
    krt_pkg::t_rec                 r_rec;
    logic [krt_pkg::STATUS_W-1:0]  r_status, n_status;

    logic [AW-1:0]                 raddr;
    krt_pkg::t_rec                 rdata;
    logic                          we;
    logic [AW-1:0]                 waddr;
    krt_pkg::t_rec                 wdata;
    logic                          key_match;
    logic                          scan_last;
    logic                          table_full;
    logic                          accept;
    logic [OW-1:0]                 count_ext;

    krt_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign key_match   = (rdata.key_high == r_req.key_high) &&
                         (rdata.key_low == r_req.key_low);
    assign scan_last   = (CW'(r_idx) + CW'(1)) >= r_count;
    assign table_full  = r_count >= CW'(TABLE_DEPTH);

    // Read address: entry 0 on a new request, the entry after the current one
    // while scanning, two ahead while shifting records down.
    always_comb begin
        unique case (r_state)
            S_IDLE:  raddr = '0;
            S_SHIFT: raddr = r_idx + AW'(2);
            default: raddr = r_idx + AW'(1);
        endcase
    end

    // Next-state logic, RAM writes and the status of the operation.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_hit    = r_hit;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = r_req;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = (r_count == '0) ? S_ACT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (key_match) begin
                    n_hit   = 1'b1;
                    n_state = S_ACT;
                end else if (scan_last) begin
                    n_state = S_ACT;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_ACT: begin
                n_status = krt_pkg::STATUS_OK;
                n_state  = S_FIN;
                case (r_mode)
                    krt_pkg::MODE_UPSERT: begin
                        if (r_hit) begin
                            we = 1'b1;
                        end else if (!table_full) begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end else begin
                            n_status = krt_pkg::STATUS_FULL;
                        end
                    end
                    krt_pkg::MODE_APPEND: begin
                        if (!table_full) begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end else begin
                            n_status = krt_pkg::STATUS_FULL;
                        end
                    end
                    krt_pkg::MODE_SET_STATE: begin
                        if (r_hit) begin
                            we          = 1'b1;
                            wdata       = r_rec;
                            wdata.state = r_req.state;
                        end else begin
                            n_status = krt_pkg::STATUS_MISSING;
                        end
                    end
                    krt_pkg::MODE_REMOVE: begin
                        if (r_hit) begin
                            n_count = r_count - CW'(1);
                            n_state = S_SHIFT;
                        end else begin
                            n_status = krt_pkg::STATUS_MISSING;
                        end
                    end
                    default: begin
                        if (!r_hit) begin
                            n_status = krt_pkg::STATUS_MISSING;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                // The count already excludes the removed record, so entries
                // below it are refilled from their successors.
                if (CW'(r_idx) < r_count) begin
                    we    = 1'b1;
                    wdata = rdata;
                    n_idx = r_idx + AW'(1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, count and request registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hit   <= n_hit;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        if (accept) begin
            r_mode <= i_mode;
            r_req  <= i_rec;
        end
        if (r_state == S_SCAN && key_match) begin
            r_rec <= rdata;
        end
    end

    // Result of the finished request.
    assign count_ext   = OW'(r_count);
    assign o_res_valid = (r_state == S_FIN);
    always_comb begin
        o_res.found  = r_hit;
        o_res.state  = r_hit ? r_rec.state : krt_pkg::MISS_STATE;
        o_res.size   = r_hit ? r_rec.size : '0;
        o_res.count  = count_ext[krt_pkg::COUNT_W-1:0];
        o_res.status = r_status;
    end

endmodule

`default_nettype wire

### src/keyed_record_table.sv
// Keyed record table: an ordered table of records searched by 128-bit key.
//
// Requests arrive on the s_ stream: tuser carries the operation code, tdata
// the key, the new state and the new size. One result per request leaves on
// the m_ stream. Two byte-addressed registers on the APB port hold the state
// codes that mean deleted and modified; pready is always high.
//
// The records live in one RAM with a registered read, and the search walks
// it one record per cycle from index 0. A request that matches at index h
// compares entries 0 to h; a miss compares every stored record (none on an
// empty table). Around the search come the accept in S_IDLE, the update in
// S_ACT and the hand-over in S_FIN; a removal copies each following record
// one place down in S_SHIFT in between. One request is in work at a time;
// the next is taken once the result has moved into the output register,
// which holds it while the receiver stalls.
//
// Reset empties the table (the count goes to zero, the RAM is not cleared)
// and loads the codes 2 and 1.
// Depends on krt_pkg, krt_ctrl and krt_ram.
`default_nettype none

module keyed_record_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Request stream.
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: key_high[63:0], key_low[127:64], new_state[135:128],
    // new_size[199:136]
    input  wire logic [199:0] i_s_tdata,
    // tuser: mode[2:0]
    input  wire logic [2:0]   i_s_tuser,
    // Result stream.
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: found[0], rec_state[8:1], rec_size[72:9], deleted_flag[73],
    // modified_flag[74], entry_count[81:75], status[83:82], zero[87:84]
    output logic [87:0]       o_m_tdata,
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [krt_pkg::STATE_W-1:0] r_deleted_code;
    logic [krt_pkg::STATE_W-1:0] r_modified_code;
    logic                        r_m_valid;
    logic [87:0]                 r_m_data;

    krt_pkg::t_rec    req_rec;
    logic             res_valid;
    logic             res_ready;
    krt_pkg::t_result res;
    logic             deleted_flag;
    logic             modified_flag;
    logic             cfg_write;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deleted_code  <= 8'd2;
            r_modified_code <= 8'd1;
        end else if (cfg_write) begin
            unique case (paddr[2])
                krt_pkg::REG_DELETED_CODE:  r_deleted_code  <= pwdata[7:0];
                krt_pkg::REG_MODIFIED_CODE: r_modified_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            krt_pkg::REG_DELETED_CODE:  prdata = {24'b0, r_deleted_code};
            krt_pkg::REG_MODIFIED_CODE: prdata = {24'b0, r_modified_code};
            default:                    prdata = '0;
        endcase
    end

    // Request unpacking.
    assign req_rec.key_high = i_s_tdata[63:0];
    assign req_rec.key_low  = i_s_tdata[127:64];
    assign req_rec.state    = i_s_tdata[135:128];
    assign req_rec.size     = i_s_tdata[199:136];

    krt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_mode      (i_s_tuser),
        .i_rec       (req_rec),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // State flags are only raised for a record that was found.
    assign deleted_flag  = res.found && (res.state == r_deleted_code);
    assign modified_flag = res.found && (res.state == r_modified_code);

    // Output register: loaded when empty or being emptied.
    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_m_data <= {4'b0, res.status, res.count, modified_flag, deleted_flag,
                         res.size, res.state, res.found};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // A request goes through the scan or update state before its result is offered.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !res_valid)
        else $error("result offered in the cycle after a request was taken");

    // A miss reports the default state, a zero size and neither flag.
    a_miss_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |->
        (o_m_tdata[8:1] == krt_pkg::MISS_STATE && o_m_tdata[72:9] == '0 &&
         !o_m_tdata[73] && !o_m_tdata[74]))
        else $error("miss reported with a record state, size or flag");

    // A found key never reports the key as missing.
    a_found_not_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[83:82] != krt_pkg::STATUS_MISSING))
        else $error("missing status reported for a key that was found");

endmodule

`default_nettype wire

### tb/krt_checker.sv
// Scoreboard for the keyed record table: watches the request, result and APB
// channels, keeps its own copy of the records and codes, and checks each result.
// Depends on krt_pkg only.
`default_nettype none

module krt_checker #(
    parameter int DEPTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Request channel as seen on the block's slave side.
    input  wire logic         i_req_valid,
    input  wire logic         i_req_ready,
    // data: key_high[63:0], key_low[127:64], new_state[135:128],
    // new_size[199:136]
    input  wire logic [199:0] i_req_data,
    // mode[2:0]
    input  wire logic [2:0]   i_req_mode,
    // Result channel as seen on the block's master side.
    input  wire logic         i_res_valid,
    input  wire logic         i_res_ready,
    // data: found[0], rec_state[8:1], rec_size[72:9], deleted_flag[73],
    // modified_flag[74], entry_count[81:75], status[83:82], zero[87:84]
    input  wire logic [87:0]  i_res_data,
    // Configuration port.
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic [2:0]   i_paddr,
    input  wire logic [31:0]  i_pwdata,
    input  wire logic [31:0]  i_prdata,
    input  wire logic         i_pready,
    // Tallies handed to the testbench top.
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results,
    output int                o_hits,
    output int                o_drops
);
    import krt_pkg::*;

    // What one request should produce on the result channel.
    typedef struct packed {
        logic                found;
        logic [STATE_W-1:0]  state;
        logic [SIZE_W-1:0]   size;
        logic                deleted;
        logic                modified;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_outcome;

    localparam logic [STATE_W-1:0] DELETED_AT_RESET  = 8'd2;
    localparam logic [STATE_W-1:0] MODIFIED_AT_RESET = 8'd1;
    localparam int                 REPORT_LIMIT      = 10;

    t_rec               records [DEPTH];
    int                 record_total;
    logic [STATE_W-1:0] deleted_code;
    logic [STATE_W-1:0] modified_code;
    t_outcome           expected_outcomes [$];

    // Count a wrong field; only the first few are printed in full.
    function automatic void flag_field(string tag, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (o_fail_count < REPORT_LIMIT)
                $display("[%0t] %s wrong: expected 0x%0h, got 0x%0h", $time, tag, want, got);
            o_fail_count++;
        end
    endfunction

    // Carry out one request on the local table and return what it reports.
    function automatic t_outcome apply_request(logic [MODE_W-1:0] op, t_rec req);
        t_outcome res;
        int       hit;
        hit = -1;
        for (int i = 0; i < record_total; i++)
            if (hit < 0 && records[i].key_high == req.key_high &&
                    records[i].key_low == req.key_low)
                hit = i;

        res        = '0;
        res.found  = (hit >= 0);
        res.state  = MISS_STATE;
        res.status = STATUS_OK;
        if (res.found) begin
            res.state = records[hit].state;
            res.size  = records[hit].size;
        end

        case (op)
            MODE_UPSERT: begin
                if (res.found) begin
                    records[hit].state = req.state;
                    records[hit].size  = req.size;
                end else if (record_total < DEPTH) begin
                    records[record_total] = req;
                    record_total++;
                end else begin
                    res.status = STATUS_FULL;
                end
            end
            MODE_APPEND: begin
                if (record_total < DEPTH) begin
                    records[record_total] = req;
                    record_total++;
                end else begin
                    res.status = STATUS_FULL;
                end
            end
            MODE_SET_STATE: begin
                if (res.found)
                    records[hit].state = req.state;
                else
                    res.status = STATUS_MISSING;
            end
            MODE_REMOVE: begin
                // The records behind the match move one place down.
                if (res.found) begin
                    for (int i = hit; i + 1 < record_total; i++)
                        records[i] = records[i + 1];
                    record_total--;
                end else begin
                    res.status = STATUS_MISSING;
                end
            end
            default: begin
                // Lookup, and the spare codes that act as one.
                if (!res.found)
                    res.status = STATUS_MISSING;
            end
        endcase

        res.deleted  = res.found && (res.state == deleted_code);
        res.modified = res.found && (res.state == modified_code);
        res.count    = COUNT_W'(record_total);
        return res;
    endfunction

    // Everything is sampled at the rising edge, results before requests.
    always @(posedge i_clk) begin : watch
        t_outcome    want;
        t_rec        req;
        logic [31:0] reg_value;
        if (!i_rst_n) begin
            record_total  = 0;
            deleted_code  = DELETED_AT_RESET;
            modified_code = MODIFIED_AT_RESET;
            expected_outcomes.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                o_results++;
                if (expected_outcomes.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT)
                        $display("[%0t] result 0x%0h arrived with no request waiting",
                                 $time, i_res_data);
                    o_fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    flag_field("found", want.found, i_res_data[0]);
                    flag_field("rec_state", want.state, i_res_data[8:1]);
                    flag_field("rec_size", want.size, i_res_data[72:9]);
                    flag_field("deleted_flag", want.deleted, i_res_data[73]);
                    flag_field("modified_flag", want.modified, i_res_data[74]);
                    flag_field("entry_count", want.count, i_res_data[81:75]);
                    flag_field("status", want.status, i_res_data[83:82]);
                    flag_field("padding", '0, i_res_data[87:84]);
                end
            end

            if (i_req_valid && i_req_ready) begin
                req.key_high = i_req_data[63:0];
                req.key_low  = i_req_data[127:64];
                req.state    = i_req_data[135:128];
                req.size     = i_req_data[199:136];
                want = apply_request(i_req_mode, req);
                if (want.found)
                    o_hits++;
                if (want.status == STATUS_FULL)
                    o_drops++;
                expected_outcomes = {expected_outcomes, want};
            end

            // Register writes update the codes; reads must return them.
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_MODIFIED_CODE)
                        modified_code = i_pwdata[STATE_W-1:0];
                    else
                        deleted_code = i_pwdata[STATE_W-1:0];
                end else begin
                    reg_value = {24'd0, (i_paddr[2] == REG_MODIFIED_CODE) ?
                                        modified_code : deleted_code};
                    flag_field("register read", reg_value, i_prdata);
                end
            end
        end
        o_pending = expected_outcomes.size();
    end

endmodule

`default_nettype wire

### tb/keyed_record_table_tb.sv
// Testbench top for the keyed record table: clock, reset, request and APB
// stimulus, receiver back-pressure and the final verdict.
// Depends on krt_pkg, keyed_record_table and krt_checker.
`default_nettype none

module keyed_record_table_tb;
    import krt_pkg::*;

    localparam int                DEPTH             = 64;
    localparam int                POOL_SIZE         = 32;
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int chk_fail;
    int chk_pending;
    int chk_results;
    int chk_hits;
    int chk_drops;

    // Stimulus bookkeeping.
    logic               steady = 1'b0;
    logic [STATE_W-1:0] cur_del = 8'd2;
    logic [STATE_W-1:0] cur_mod = 8'd1;
    logic [KEY_W-1:0]   pool_hi [POOL_SIZE];
    logic [KEY_W-1:0]   pool_lo [POOL_SIZE];
    int                 requests_sent = 0;
    int                 code_settings = 1;

    keyed_record_table #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    krt_checker #(.DEPTH(DEPTH)) scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_req_mode   (s_tuser),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (chk_fail),
        .o_pending    (chk_pending),
        .o_results    (chk_results),
        .o_hits       (chk_hits),
        .o_drops      (chk_drops)
    );

    always #6 clk = ~clk;

    // The receiver stalls now and then, except during a steady stretch.
    always @(negedge clk) begin
        m_tready <= steady || ($urandom_range(99) >= 16);
    end

    // Hard stop in case the block hangs.
    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] kh,
                                input logic [KEY_W-1:0] kl, input logic [STATE_W-1:0] st,
                                input logic [SIZE_W-1:0] sz);
        while (!steady && $urandom_range(99) < 16) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {sz, st, kl, kh};
        s_tuser  = op;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        requests_sent++;
    endtask

    // One APB transfer: setup phase, then access phase until pready.
    task automatic apb_access(input logic wr, input logic regsel, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {regsel, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
    endtask

    // Load both codes while idle and read them back.
    task automatic set_codes(input logic [STATE_W-1:0] del, input logic [STATE_W-1:0] md);
        wait_drained();
        apb_access(1'b1, REG_DELETED_CODE, {24'd0, del});
        apb_access(1'b1, REG_MODIFIED_CODE, {24'd0, md});
        apb_access(1'b0, REG_DELETED_CODE, '0);
        apb_access(1'b0, REG_MODIFIED_CODE, '0);
        cur_del = del;
        cur_mod = md;
        code_settings++;
    endtask

    // States lean towards the two codes and the extremes.
    function automatic logic [STATE_W-1:0] pick_state();
        int roll;
        roll = $urandom_range(9);
        if (roll < 3)
            return cur_del;
        if (roll < 6)
            return cur_mod;
        if (roll == 6)
            return '0;
        if (roll == 7)
            return '1;
        return STATE_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly keys from the front of the pool so that hits are common.
    task automatic pick_key(input int span, output logic [KEY_W-1:0] kh,
                            output logic [KEY_W-1:0] kl);
        int slot;
        if ($urandom_range(9) == 0) begin
            kh = {$urandom, $urandom};
            kl = {$urandom, $urandom};
        end else begin
            slot = $urandom_range(span - 1);
            kh   = pool_hi[slot];
            kl   = pool_lo[slot];
        end
    endtask

    // A run of random requests with the given operation weights.
    task automatic run_segment(input int n, input int span, input int w_look,
                               input int w_ups, input int w_app, input int w_set,
                               input int w_rem, input int w_odd);
        int                 roll;
        logic [MODE_W-1:0]  op;
        logic [KEY_W-1:0]   kh;
        logic [KEY_W-1:0]   kl;
        repeat (n) begin
            roll = $urandom_range(w_look + w_ups + w_app + w_set + w_rem + w_odd - 1);
            if (roll < w_look)
                op = MODE_LOOKUP;
            else if (roll < w_look + w_ups)
                op = MODE_UPSERT;
            else if (roll < w_look + w_ups + w_app)
                op = MODE_APPEND;
            else if (roll < w_look + w_ups + w_app + w_set)
                op = MODE_SET_STATE;
            else if (roll < w_look + w_ups + w_app + w_set + w_rem)
                op = MODE_REMOVE;
            else
                op = MODE_UNUSED_FIRST + MODE_W'($urandom_range(2));
            pick_key(span, kh, kl);
            send_request(op, kh, kl, pick_state(), pick_size());
        end
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0] ones;
        logic [KEY_W-1:0] zero;
        ones = '1;
        zero = '0;

        // Key pool: a random key, two near misses of it, the extremes, then random.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        pool_hi[1] = pool_hi[0] ^ (64'd1 << $urandom_range(63));
        pool_lo[1] = pool_lo[0];
        pool_hi[2] = pool_hi[0];
        pool_lo[2] = pool_lo[0] ^ (64'd1 << $urandom_range(63));
        pool_hi[3] = zero;
        pool_lo[3] = zero;
        pool_hi[4] = ones;
        pool_lo[4] = ones;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset codes: misses on an empty table,
        // upsert as append, duplicates, overwrite, flags, partial keys,
        // spare codes and removal with the gap closed.
        send_request(MODE_LOOKUP, zero, zero, 8'd0, '0);
        send_request(MODE_REMOVE, zero, zero, 8'd0, '0);
        send_request(MODE_SET_STATE, zero, zero, 8'hFF, '0);
        send_request(MODE_UPSERT, zero, zero, 8'd0, '0);
        send_request(MODE_UPSERT, ones, ones, 8'hFF, '1);
        send_request(MODE_LOOKUP, zero, zero, 8'd0, '0);
        send_request(MODE_LOOKUP, ones, ones, 8'd0, '0);
        send_request(MODE_APPEND, zero, zero, cur_del, 64'h5555_5555_5555_5555);
        send_request(MODE_LOOKUP, zero, zero, 8'd0, '0);
        send_request(MODE_UPSERT, zero, zero, cur_mod, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(MODE_LOOKUP, zero, zero, 8'd0, '0);
        send_request(MODE_SET_STATE, ones, ones, cur_del, '0);
        send_request(MODE_LOOKUP, ones, ones, 8'd0, '0);
        send_request(MODE_LOOKUP, ones, zero, 8'd0, '0);
        send_request(MODE_LOOKUP, zero, ones, 8'd0, '0);
        send_request(MODE_UNUSED_FIRST, ones, ones, 8'hFF, '1);
        send_request(MODE_UNUSED_FIRST + 3'd1, zero, zero, 8'hFF, '1);
        send_request(MODE_UNUSED_LAST, ones, zero, 8'hFF, '1);
        send_request(MODE_REMOVE, zero, zero, 8'd0, '0);
        send_request(MODE_LOOKUP, zero, zero, 8'd0, '0);
        send_request(MODE_LOOKUP, ones, ones, 8'd0, '0);
        send_request(MODE_REMOVE, ones, ones, 8'd0, '0);
        send_request(MODE_REMOVE, zero, zero, 8'd0, '0);
        send_request(MODE_LOOKUP, zero, zero, 8'd0, '0);

        // Mixed traffic on a few keys, extreme codes.
        set_codes(8'd0, 8'hFF);
        run_segment(200, 8, 25, 25, 10, 15, 20, 5);

        // Fill the table past full with no idling on either side.
        set_codes(8'hFF, 8'd0);
        steady = 1'b1;
        run_segment(100, POOL_SIZE, 5, 10, 80, 5, 0, 0);
        steady = 1'b0;

        // Drain it again, mostly removals.
        set_codes(STATE_W'($urandom), STATE_W'($urandom));
        run_segment(120, POOL_SIZE, 15, 10, 5, 10, 60, 0);

        // Both codes equal, so a match can carry both flags.
        begin : same_codes
            logic [STATE_W-1:0] code;
            code = STATE_W'($urandom);
            set_codes(code, code);
        end
        run_segment(180, 16, 25, 25, 10, 15, 20, 5);

        wait_drained();
        repeat (200) @(negedge clk);

        $display("Covered %0d requests and %0d results under %0d code settings;",
                 requests_sent, chk_results, code_settings);
        $display("%0d requests matched a key and %0d were dropped on a full table.",
                 chk_hits, chk_drops);
        if (chk_fail == 0 && chk_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
